/* src/frequency_ordered_cache_assert.svh */
// ----------------------------------------------------------------------------
// frequency_ordered_cache assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet under rst_n.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_CACHE_ASSERT_SVH
`define FREQUENCY_ORDERED_CACHE_ASSERT_SVH

// same-cycle implication
`define FOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/foc_pkg.sv */
// ----------------------------------------------------------------------------
// foc_pkg
// Shared constants, cell control struct and sequencer states of the
// count-ranked cache.
// ----------------------------------------------------------------------------
`default_nettype none

package foc_pkg;

  // payload field width of every key and value beat
  localparam int unsigned FIELD_W = 32;

  // defaults for the top-level parameters
  localparam int unsigned DEF_MAX_ENTRIES = 16;
  localparam int unsigned DEF_KEY_WIDTH   = 32;
  localparam int unsigned DEF_COUNT_WIDTH = 16;

  // capacity register
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(5);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  // per-cell update controls
  typedef struct packed {
    logic upd;           // apply the update this cycle
    logic hit;           // lookup hit, otherwise a fill
    logic before_found;  // cell ranks ahead of the hit entry
    logic at_found;      // cell holds the hit entry
    logic at_insert;     // cell receives the fill entry
  } foc_cell_ctl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } foc_state_t;

endpackage

`default_nettype wire

/* src/foc_if.sv */
// ----------------------------------------------------------------------------
// foc_if
// Valid/ready channels of the count-ranked cache: lookup, result and
// capacity configuration.
// ----------------------------------------------------------------------------
`default_nettype none

// lookup channel
interface foc_in_if;
  logic                        valid;
  logic                        ready;
  logic [foc_pkg::FIELD_W-1:0] key;
  logic [foc_pkg::FIELD_W-1:0] fill_value;

  modport source (output valid, output key, output fill_value, input ready);
  modport sink   (input valid, input key, input fill_value, output ready);
endinterface

// result channel
interface foc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [foc_pkg::FIELD_W-1:0] value;
  logic                        evicted;
  logic [foc_pkg::FIELD_W-1:0] evicted_key;

  modport source (output valid, output hit, output value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input value, input evicted,
                  input evicted_key, output ready);
endinterface

// capacity write channel
interface foc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [foc_pkg::CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/foc_cell.sv */
// ----------------------------------------------------------------------------
// foc_cell
// One rank of the cache: holds key, value and use count, compares the
// lookup key, and on update holds, loads a new entry or takes its
// predecessor's entry as the hit entry moves ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_cell #(
  parameter int unsigned KEY_W   = foc_pkg::DEF_KEY_WIDTH,
  parameter int unsigned COUNT_W = foc_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire foc_pkg::foc_cell_ctl_t      ctl,
  input  wire logic                        held,
  input  wire logic [KEY_W-1:0]            lookup_key,
  input  wire logic [KEY_W-1:0]            load_key,
  input  wire logic [foc_pkg::FIELD_W-1:0] load_value,
  input  wire logic [COUNT_W-1:0]          load_count,
  input  wire logic [KEY_W-1:0]            prev_key,
  input  wire logic [foc_pkg::FIELD_W-1:0] prev_value,
  input  wire logic [COUNT_W-1:0]          prev_count,
  input  wire logic                        prev_move,
  output logic [KEY_W-1:0]                 key,
  output logic [foc_pkg::FIELD_W-1:0]      value,
  output logic [COUNT_W-1:0]               count,
  output logic                             move,
  output logic                             match
);

  logic [KEY_W-1:0]            key_r,   key_nxt;
  logic [foc_pkg::FIELD_W-1:0] value_r, value_nxt;
  logic [COUNT_W-1:0]          count_r, count_nxt;
  logic                        take_hit;
  logic                        shift_in;
  logic                        load;

  // lookup compare
  assign match = held & (key_r == lookup_key);

  // this rank steps down one place when the hit entry passes it
  assign move     = ctl.upd & ctl.hit & ctl.before_found & (count_r < load_count);
  assign take_hit = ctl.upd & ctl.hit & (ctl.at_found | move);
  assign shift_in = take_hit & prev_move;
  assign load     = ctl.upd & ((take_hit & ~prev_move) | (~ctl.hit & ctl.at_insert));

  // next entry
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    count_nxt = count_r;
    if (shift_in) begin
      key_nxt   = prev_key;
      value_nxt = prev_value;
      count_nxt = prev_count;
    end else if (load) begin
      key_nxt   = load_key;
      value_nxt = load_value;
      count_nxt = load_count;
    end
  end

  // use count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // key and value storage
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key   = key_r;
  assign value = value_r;
  assign count = count_r;

endmodule

`default_nettype wire

/* src/frequency_ordered_cache.sv */
// ----------------------------------------------------------------------------
// frequency_ordered_cache
// Key/value cache kept as a row of cells ranked by use count.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one lookup per beat (key, fill_value). out_if returns one
//   result beat per lookup: hit, the value now held, and the evicted key
//   when a fill had to throw out the tail entry. cfg_if writes the capacity
//   (clamped to 5..MAX_ENTRIES); write it only while no lookup is in flight.
//   At the accept edge every cell compares its key and the hit entry's
//   count, value and the tail key are captured; in the update state that
//   follows, the cells shift in parallel to re-rank the hit entry or
//   append the fill at the tail. The cell row is the only resource, so one
//   lookup is in flight at a time and in_if.ready is high in the idle cycle.
//   The result sits in an output register loaded at the update edge, and the
//   next lookup is accepted while it waits.
//   If out_if stalls with a result still held, the update cycle waits.
//   Reset empties the cache and sets capacity to 10; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_ordered_cache #(
  parameter int unsigned MAX_ENTRIES = foc_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned KEY_WIDTH   = foc_pkg::DEF_KEY_WIDTH,
  parameter int unsigned COUNT_WIDTH = foc_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  foc_in_if.sink     in_if,
  foc_out_if.source  out_if,
  foc_cfg_if.sink    cfg_if
);

  localparam int unsigned FW    = foc_pkg::FIELD_W;
  localparam int unsigned KW    = (KEY_WIDTH < FW) ? KEY_WIDTH : FW;
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned IW    = $clog2(MAX_ENTRIES);
  localparam int unsigned HW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (HW > foc_pkg::CAP_W) ? HW : foc_pkg::CAP_W;

  foc_pkg::foc_state_t state_r, state_nxt;

  logic [foc_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [HW-1:0]             held_r, held_nxt;

  // captured lookup
  logic [KW-1:0] key_r;
  logic [FW-1:0] fill_r;
  logic          hit_r;
  logic [IW-1:0] found_idx_r;
  logic [FW-1:0] hit_val_r;
  logic [CW-1:0] new_cnt_r;
  logic          evict_r;
  logic [FW-1:0] evict_key_r;
  logic [HW-1:0] ins_pos_r;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r;
  logic [FW-1:0] out_value_r;
  logic          out_evicted_r;
  logic [FW-1:0] out_evkey_r;

  // cell row
  logic [KW-1:0]          cell_key   [MAX_ENTRIES];
  logic [FW-1:0]          cell_value [MAX_ENTRIES];
  logic [CW-1:0]          cell_count [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_move;
  logic [MAX_ENTRIES-1:0] cell_match;
  logic [MAX_ENTRIES-1:0] cell_held;
  logic [MAX_ENTRIES-1:0] cell_tail;
  foc_pkg::foc_cell_ctl_t cell_ctl [MAX_ENTRIES];

  logic [KW-1:0] lookup_key;
  logic [KW-1:0] load_key;
  logic [FW-1:0] load_value;
  logic [CW-1:0] load_count;

  logic          in_fire;
  logic          upd_go;
  logic          any_hit;
  logic          evict_now;
  logic          ins_wr;
  logic [IW-1:0] found_idx;
  logic [FW-1:0] sel_value;
  logic [CW-1:0] sel_count;
  logic [KW-1:0] tail_key;
  logic [HW-1:0] tail_pos;

  // handshakes
  assign in_if.ready  = (state_r == foc_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid & in_if.ready;
  assign upd_go       = (state_r == foc_pkg::ST_UPD) & (~out_valid_r | out_if.ready);

  assign lookup_key = in_if.key[KW-1:0];
  assign tail_pos   = held_r - 1'b1;

  // hit and tail selection across the row
  always_comb begin
    found_idx = '0;
    sel_value = '0;
    sel_count = '0;
    tail_key  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cell_match[i]) begin
        found_idx = found_idx | IW'(i);
        sel_value = sel_value | cell_value[i];
        sel_count = sel_count | cell_count[i];
      end
      if (cell_tail[i]) begin
        tail_key = tail_key | cell_key[i];
      end
    end
  end

  assign any_hit   = |cell_match;
  assign evict_now = ~any_hit & (held_r != '0) & (CMP_W'(held_r) >= CMP_W'(cap_r));

  // capture the lookup at the accept edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r       <= lookup_key;
      fill_r      <= in_if.fill_value;
      hit_r       <= any_hit;
      found_idx_r <= found_idx;
      hit_val_r   <= sel_value;
      new_cnt_r   <= (sel_count == '1) ? sel_count : sel_count + 1'b1;
      evict_r     <= evict_now;
      evict_key_r <= evict_now ? FW'(tail_key) : '0;
      ins_pos_r   <= evict_now ? tail_pos : held_r;
    end
  end

  // entry offered to the row
  assign ins_wr     = (ins_pos_r < MAX_ENTRIES);
  assign load_key   = key_r;
  assign load_value = hit_r ? hit_val_r : fill_r;
  assign load_count = hit_r ? new_cnt_r : '0;

  // row of cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [KW-1:0] prev_key;
    logic [FW-1:0] prev_value;
    logic [CW-1:0] prev_count;
    logic          prev_move;

    if (g == 0) begin : g_head
      assign prev_key   = '0;
      assign prev_value = '0;
      assign prev_count = '0;
      assign prev_move  = 1'b0;
    end else begin : g_body
      assign prev_key   = cell_key[g-1];
      assign prev_value = cell_value[g-1];
      assign prev_count = cell_count[g-1];
      assign prev_move  = cell_move[g-1];
    end

    assign cell_held[g]              = (HW'(g) < held_r);
    assign cell_tail[g]              = (HW'(g) == tail_pos);
    assign cell_ctl[g].upd           = upd_go;
    assign cell_ctl[g].hit           = hit_r;
    assign cell_ctl[g].before_found  = (IW'(g) < found_idx_r);
    assign cell_ctl[g].at_found      = (IW'(g) == found_idx_r);
    assign cell_ctl[g].at_insert     = ins_wr & (HW'(g) == ins_pos_r);

    foc_cell #(
      .KEY_W   (KW),
      .COUNT_W (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl[g]),
      .held       (cell_held[g]),
      .lookup_key (lookup_key),
      .load_key   (load_key),
      .load_value (load_value),
      .load_count (load_count),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .prev_count (prev_count),
      .prev_move  (prev_move),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .count      (cell_count[g]),
      .move       (cell_move[g]),
      .match      (cell_match[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      foc_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = foc_pkg::ST_UPD;
      end
      foc_pkg::ST_UPD: begin
        if (upd_go) state_nxt = foc_pkg::ST_IDLE;
      end
      default: state_nxt = foc_pkg::ST_IDLE;
    endcase
  end

  // fill level
  always_comb begin
    held_nxt = held_r;
    if (upd_go && !hit_r) begin
      held_nxt = ins_wr ? ins_pos_r + 1'b1 : ins_pos_r;
    end
  end

  // capacity register with clamping
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.data < foc_pkg::CAP_MIN) begin
        cap_nxt = foc_pkg::CAP_MIN;
      end else if (32'(cfg_if.data) > MAX_ENTRIES) begin
        cap_nxt = foc_pkg::CAP_W'(MAX_ENTRIES);
      end else begin
        cap_nxt = cfg_if.data;
      end
    end
  end

  // result beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= foc_pkg::ST_IDLE;
      held_r      <= '0;
      cap_r       <= foc_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_hit_r     <= hit_r;
      out_value_r   <= load_value;
      out_evicted_r <= evict_r;
      out_evkey_r   <= evict_key_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.hit         = out_hit_r;
  assign out_if.value       = out_value_r;
  assign out_if.evicted     = out_evicted_r;
  assign out_if.evicted_key = out_evkey_r;

  // checks
  `include "frequency_ordered_cache_assert.svh"

  `FOC_ASSERT_NOW(a_held_bound, 1'b1, held_r <= MAX_ENTRIES, "fill level beyond row length")
  `FOC_ASSERT_NOW(a_unique_key, state_r == foc_pkg::ST_IDLE, $onehot0(cell_match), "key held twice")
  `FOC_ASSERT_NEXT(a_accept_upd, in_fire, state_r == foc_pkg::ST_UPD, "accept without update")
  `FOC_ASSERT_NEXT(a_result_src, upd_go, out_valid_r, "update without result beat")

endmodule

`default_nettype wire

/* dv/frequency_ordered_cache_tb.sv */
// ----------------------------------------------------------------------------
// frequency_ordered_cache_tb
// Drives lookups into the count-ranked cache and checks every result beat
// against a ranked-list predictor. The run covers directed corner cases and
// random phases across many capacity settings, with random gaps on the
// sender, stalls on the receiver and long hold-offs.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_ordered_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import foc_pkg::*;

  localparam int unsigned SLOTS        = DEF_MAX_ENTRIES;
  localparam int unsigned COUNT_W      = DEF_COUNT_WIDTH;
  localparam int unsigned RAND_ITEMS   = 1100;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  typedef logic [FIELD_W-1:0] word_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic  hit;
    word_t value;
    logic  evicted;
    word_t evicted_key;
  } lookup_result_t;

  // ranked-list predictor and store of expected result beats
  class lookup_scoreboard;
    word_t          held_key[SLOTS];
    word_t          held_value[SLOTS];
    count_t         held_count[SLOTS];
    int unsigned    held_n;
    int unsigned    capacity;
    int unsigned    failures;
    lookup_result_t pending_results[$];

    function new();
      held_n   = 0;
      capacity = CAP_RESET;
      failures = 0;
      foreach (held_count[i]) begin
        held_key[i]   = '0;
        held_value[i] = '0;
        held_count[i] = '0;
      end
    endfunction

    function void set_capacity(logic [CAP_W-1:0] data);
      if (data < CAP_MIN) begin
        capacity = CAP_MIN;
      end else if (data > SLOTS) begin
        capacity = SLOTS;
      end else begin
        capacity = data;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_lookup(word_t key, word_t fill);
      lookup_result_t r;
      int             pos;
      int             dest;
      count_t         cnt;
      word_t          val;
      pos = -1;
      for (int i = 0; i < held_n; i++) begin
        if (pos < 0 && held_key[i] == key) pos = i;
      end
      if (pos >= 0) begin
        // hit: bump the count and move ahead of strictly lower predecessors
        cnt = held_count[pos];
        val = held_value[pos];
        if (cnt != '1) cnt++;
        dest = pos;
        while (dest > 0 && held_count[dest-1] < cnt) dest--;
        for (int i = pos; i > dest; i--) begin
          held_key[i]   = held_key[i-1];
          held_value[i] = held_value[i-1];
          held_count[i] = held_count[i-1];
        end
        held_key[dest]   = key;
        held_value[dest] = val;
        held_count[dest] = cnt;
        r = '{hit: 1'b1, value: val, evicted: 1'b0, evicted_key: '0};
      end else begin
        // miss: evict the tail when at or over capacity, then append
        r = '{hit: 1'b0, value: fill, evicted: 1'b0, evicted_key: '0};
        if (held_n > 0 && held_n >= capacity) begin
          held_n--;
          r.evicted     = 1'b1;
          r.evicted_key = held_key[held_n];
        end
        if (held_n < SLOTS) begin
          held_key[held_n]   = key;
          held_value[held_n] = fill;
          held_count[held_n] = '0;
          held_n++;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no lookup outstanding");
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        failures++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %h, got %h", want.value, got.value);
        failures++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
        failures++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  foc_in_if  in_ch ();
  foc_out_if out_ch ();
  foc_cfg_if cfg_ch ();

  frequency_ordered_cache u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  lookup_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  bit          hold_off_request = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle counter and run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // beat monitor: note accepted lookups, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_lookup(in_ch.key, in_ch.fill_value);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{hit: out_ch.hit, value: out_ch.value,
                          evicted: out_ch.evicted, evicted_key: out_ch.evicted_key});
      end
    end
  end

  // receiver: segments of differing stall patterns, plus an occasional long hold-off
  initial begin
    int unsigned seg;
    int unsigned mode;
    int unsigned hold;
    int unsigned rx_cycle;
    seg      = 0;
    mode     = 0;
    hold     = 0;
    rx_cycle = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (seg == 0) begin
        seg  = $urandom_range(20, 200);
        mode = $urandom_range(0, 3);
      end
      seg--;
      rx_cycle++;
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            out_ch.ready <= ($urandom_range(0, 1) != 0);
          end
          default: begin
            out_ch.ready <= ((rx_cycle % 5) < 3);
          end
        endcase
      end
    end
  end

  // offer one lookup beat, with burst gaps, and wait for its acceptance
  task automatic offer_lookup(word_t key, word_t fill);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.key        <= key;
    in_ch.fill_value <= fill;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_capacity(data);
  endtask

  // random lookups over a skewed key pool of the capacity plus up to ten keys
  task automatic random_lookups(int unsigned n);
    word_t       pool[$];
    int unsigned pool_n;
    word_t       key;
    pool_n = sb.capacity + $urandom_range(0, 10);
    repeat (pool_n) pool.push_back($urandom);
    if ($urandom_range(0, 1)) pool[0] = '0;
    if ($urandom_range(0, 1)) pool[1] = '1;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        key = $urandom;
      end else begin
        key = pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
      end
      offer_lookup(key, $urandom);
    end
  endtask

  // main sequence
  initial begin
    logic [CAP_W-1:0] phase_caps[12];
    phase_caps = '{5'd31, 5'd0, 5'd16, 5'd4, 5'd17, 5'd5,
                   5'd16, 5'd5, 5'd12, 5'd9, 5'd16, 5'd7};
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.key        <= '0;
    in_ch.fill_value <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme keys and values, tie order, overtaking, eviction
    offer_lookup(32'h0000_0000, 32'h0000_0000);
    offer_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_lookup(32'h0000_0000, 32'h1234_5678);
    offer_lookup(32'hFFFF_FFFF, 32'h0000_0000);
    offer_lookup(32'hFFFF_FFFF, 32'h5555_5555);
    for (int i = 1; i <= 9; i++) offer_lookup(word_t'(i), 32'hA5A5_A5A5 ^ word_t'(i));
    offer_lookup(32'h0000_0005, 32'hAAAA_AAAA);
    offer_lookup(32'h0000_0005, 32'h0F0F_0F0F);
    offer_lookup(32'h8000_0001, 32'hF0F0_F0F0);
    drain();

    // random phases over capacity settings, including lowering below holdings
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      if (p == 2 || p == 8) hold_off_request = 1'b1;
      random_lookups(RAND_ITEMS / 12);
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
